>>> rtl/crg_pkg.sv
// Shared constants, a type and a helper function of the camera ray generator.
`timescale 1ns / 1ps
`default_nettype none

package crg_pkg;

    // Pixel coordinate bits that take part in the mapping.
    localparam int COORD_BITS = 16;

    // Configuration register indexes.
    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_SCALES = 3'd1;
    localparam logic [2:0] REG_RECIPS = 3'd2;
    localparam logic [2:0] REG_ROT0   = 3'd3;
    localparam logic [2:0] REG_ROT1   = 3'd4;
    localparam logic [2:0] REG_ROT2   = 3'd5;
    localparam logic [2:0] REG_POS    = 3'd6;
    localparam logic [2:0] REG_LOOK   = 3'd7;

    // Cycles from an accepted pixel to its result strobe.
    localparam int PIPE_LATENCY = 57;

    // Steps of the square root and of the divider.
    localparam int SQ_STEPS  = 31;
    localparam int DIV_STEPS = 17;

    // Data carried beside the normalization unit.
    typedef struct packed {
        logic signed [20:0] ox;
        logic signed [20:0] oy;
        logic [30:0]        mag_x;
        logic [30:0]        mag_y;
        logic               neg_x;
        logic               neg_y;
    } t_side;

    // Saturate a wide signed value to the 21-bit output range.
    function automatic logic signed [20:0] sat21(input logic signed [63:0] v);
        logic signed [20:0] res;
        if (v > 64'sd1048575) begin
            res = 21'sd1048575;
        end else if (v < -64'sd1048576) begin
            res = -21'sd1048576;
        end else begin
            res = v[20:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> rtl/camera_primary_ray_generator.sv
// Top level of the pinhole camera primary ray generator.
//
//  Channel   Signals                                   Handshake
//  pixel in  i_pixel_x, i_pixel_y                      start high, busy low
//  ray out   o_origin_x/y/z, o_direction_x/y/z         o_valid, one cycle
//  config    i_cfg_we, i_cfg_idx, i_cfg_data           write on i_cfg_we
//
// A new pixel may be transferred in every cycle; busy is always low.
// Each ray passes the mapping stages, the 31-step square root,
// the 17-step divider and the rotation stages.
// Reset is synchronous and clears the configuration registers and all stage valid bits.
// The receiver cannot stall, so the pipeline advances every cycle.
`timescale 1ns / 1ps
`default_nettype none

module camera_primary_ray_generator (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [15:0]         i_pixel_x,
    input  wire logic [15:0]         i_pixel_y,
    input  wire logic                i_cfg_we,
    input  wire logic [2:0]          i_cfg_idx,
    input  wire logic [62:0]         i_cfg_data,
    output logic                     o_valid,
    output logic signed [20:0]       o_origin_x,
    output logic signed [20:0]       o_origin_y,
    output logic signed [20:0]       o_origin_z,
    output logic signed [20:0]       o_direction_x,
    output logic signed [20:0]       o_direction_y,
    output logic signed [20:0]       o_direction_z
);

    localparam int CB     = crg_pkg::COORD_BITS;
    localparam int PROD_W = CB + 24;
    localparam int NDC_W  = PROD_W + 2;
    localparam int A_W    = NDC_W - 11;
    localparam int M_W    = A_W + 21;

    localparam logic signed [NDC_W-1:0] NDC_ONE = NDC_W'(64'd1 << 28);
    localparam logic signed [NDC_W:0]   RND16   = (NDC_W+1)'(64'd1 << 15);
    localparam logic signed [NDC_W:0]   RND12   = (NDC_W+1)'(64'd1 << 11);
    localparam logic signed [M_W:0]     MRND    = (M_W+1)'(64'd1 << 15);

    // Configuration registers.
    logic        r_mode;
    logic [39:0] r_scales;
    logic [47:0] r_recips;
    logic [56:0] r_rot [0:2];
    logic [62:0] r_pos;
    logic [62:0] r_look;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b0;
            r_scales <= '0;
            r_recips <= '0;
            r_rot[0] <= '0;
            r_rot[1] <= '0;
            r_rot[2] <= '0;
            r_pos    <= '0;
            r_look   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                crg_pkg::REG_MODE:   r_mode   <= i_cfg_data[0];
                crg_pkg::REG_SCALES: r_scales <= i_cfg_data[39:0];
                crg_pkg::REG_RECIPS: r_recips <= i_cfg_data[47:0];
                crg_pkg::REG_ROT0:   r_rot[0] <= i_cfg_data[56:0];
                crg_pkg::REG_ROT1:   r_rot[1] <= i_cfg_data[56:0];
                crg_pkg::REG_ROT2:   r_rot[2] <= i_cfg_data[56:0];
                crg_pkg::REG_POS:    r_pos    <= i_cfg_data;
                crg_pkg::REG_LOOK:   r_look   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic signed [20:0] pos_x, pos_y, pos_z;
    assign pos_x = $signed(r_pos[20:0]);
    assign pos_y = $signed(r_pos[41:21]);
    assign pos_z = $signed(r_pos[62:42]);

    assign busy = 1'b0;

    // Stage valid bits.
    logic [5:0] r_v;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[4:0], start};
        end
    end

    // Stage 1: pixel times reciprocal.
    logic [PROD_W-1:0] r_s1_px, r_s1_py;
    always_ff @(posedge i_clk) begin
        r_s1_px <= PROD_W'(i_pixel_x[CB-1:0]) * PROD_W'(r_recips[23:0]);
        r_s1_py <= PROD_W'(i_pixel_y[CB-1:0]) * PROD_W'(r_recips[47:24]);
    end

    // Stage 2: device coordinates, orthographic origin and Q.16 ndc.
    logic signed [NDC_W-1:0] nx, ny;
    logic signed [NDC_W:0]   ox16, oy16, ax12, ay12;
    logic signed [A_W-1:0]   r_s2_ax, r_s2_ay;
    logic signed [20:0]      r_s2_ox, r_s2_oy;
    assign nx   = $signed({1'b0, r_s1_px, 1'b0}) - NDC_ONE;
    assign ny   = $signed({1'b0, r_s1_py, 1'b0}) - NDC_ONE;
    assign ox16 = ($signed({nx[NDC_W-1], nx}) + RND16) >>> 16;
    assign oy16 = ($signed({ny[NDC_W-1], ny}) + RND16) >>> 16;
    assign ax12 = ($signed({nx[NDC_W-1], nx}) + RND12) >>> 12;
    assign ay12 = ($signed({ny[NDC_W-1], ny}) + RND12) >>> 12;
    always_ff @(posedge i_clk) begin
        r_s2_ox <= crg_pkg::sat21(64'(ox16) + 64'(pos_x));
        r_s2_oy <= crg_pkg::sat21(64'(oy16) + 64'(pos_y));
        r_s2_ax <= ax12[A_W-1:0];
        r_s2_ay <= ay12[A_W-1:0];
    end

    // Stage 3: scale by the view terms.
    logic signed [M_W-1:0] r_s3_mx, r_s3_my;
    logic signed [20:0]    r_s3_ox, r_s3_oy;
    always_ff @(posedge i_clk) begin
        r_s3_mx <= r_s2_ax * $signed({1'b0, r_scales[19:0]});
        r_s3_my <= r_s2_ay * $signed({1'b0, r_scales[39:20]});
        r_s3_ox <= r_s2_ox;
        r_s3_oy <= r_s2_oy;
    end

    // Stage 4: round to Q.16, saturate and split into sign and magnitude.
    logic signed [M_W:0] rdx, rdy;
    logic signed [31:0]  dcx, dcy;
    assign rdx = ($signed({r_s3_mx[M_W-1], r_s3_mx}) + MRND) >>> 16;
    assign rdy = ($signed({r_s3_my[M_W-1], r_s3_my}) + MRND) >>> 16;
    assign dcx = (64'(rdx) > 64'sd1073741824)  ? 32'sd1073741824 :
                 (64'(rdx) < -64'sd1073741824) ? -32'sd1073741824 : 32'(rdx);
    assign dcy = (64'(rdy) > 64'sd1073741824)  ? 32'sd1073741824 :
                 (64'(rdy) < -64'sd1073741824) ? -32'sd1073741824 : 32'(rdy);

    crg_pkg::t_side r_s4_side;
    logic [31:0]    abs_x, abs_y;
    assign abs_x = dcx[31] ? 32'(-dcx) : 32'(dcx);
    assign abs_y = dcy[31] ? 32'(-dcy) : 32'(dcy);
    always_ff @(posedge i_clk) begin
        r_s4_side.ox    <= r_s3_ox;
        r_s4_side.oy    <= r_s3_oy;
        r_s4_side.mag_x <= abs_x[30:0];
        r_s4_side.mag_y <= abs_y[30:0];
        r_s4_side.neg_x <= dcx[31];
        r_s4_side.neg_y <= dcy[31];
    end

    // Stage 5: squares of the magnitudes.
    logic [61:0]    r_s5_qx, r_s5_qy;
    crg_pkg::t_side r_s5_side;
    always_ff @(posedge i_clk) begin
        r_s5_qx   <= 62'(r_s4_side.mag_x) * 62'(r_s4_side.mag_x);
        r_s5_qy   <= 62'(r_s4_side.mag_y) * 62'(r_s4_side.mag_y);
        r_s5_side <= r_s4_side;
    end

    // Stage 6: squared length including the unit z term.
    logic [61:0]    r_s6_sq;
    crg_pkg::t_side r_s6_side;
    always_ff @(posedge i_clk) begin
        r_s6_sq   <= r_s5_qx + r_s5_qy + 62'(64'd1 << 32);
        r_s6_side <= r_s5_side;
    end

    // Normalization: square root, then divide each component.
    logic               nm_valid;
    logic signed [17:0] u_x, u_y, u_z;
    crg_pkg::t_side     nm_side;

    crg_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v[5]),
        .i_sq    (r_s6_sq),
        .i_side  (r_s6_side),
        .o_valid (nm_valid),
        .o_u_x   (u_x),
        .o_u_y   (u_y),
        .o_u_z   (u_z),
        .o_side  (nm_side)
    );

    // Rotation products.
    logic signed [36:0] r_p [0:2][0:2];
    logic               r_r1_v;
    crg_pkg::t_side     r_r1_side;
    logic signed [17:0] uv [0:2];
    assign uv[0] = u_x;
    assign uv[1] = u_y;
    assign uv[2] = u_z;

    for (genvar i = 0; i < 3; i++) begin : g_row
        for (genvar j = 0; j < 3; j++) begin : g_col
            always_ff @(posedge i_clk) begin
                r_p[i][j] <= $signed(r_rot[i][19*j+18 -: 19]) * uv[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_r1_side <= nm_side;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r1_v <= 1'b0;
        end else begin
            r_r1_v <= nm_valid;
        end
    end

    // Sum, round and select the result for the projection mode.
    logic signed [38:0] acc [0:2];
    logic signed [20:0] rot_res [0:2];
    for (genvar i = 0; i < 3; i++) begin : g_sum
        assign acc[i] = (39'(r_p[i][0]) + 39'(r_p[i][1]) + 39'(r_p[i][2])
                         + 39'sd32768) >>> 16;
        assign rot_res[i] = crg_pkg::sat21(64'(acc[i]));
    end

    logic               r_ov;
    logic signed [20:0] r_o [0:5];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_mode) begin
            r_o[0] <= r_r1_side.ox;
            r_o[1] <= r_r1_side.oy;
            r_o[2] <= pos_z;
            r_o[3] <= $signed(r_look[20:0]);
            r_o[4] <= $signed(r_look[41:21]);
            r_o[5] <= $signed(r_look[62:42]);
        end else begin
            r_o[0] <= pos_x;
            r_o[1] <= pos_y;
            r_o[2] <= pos_z;
            r_o[3] <= rot_res[0];
            r_o[4] <= rot_res[1];
            r_o[5] <= rot_res[2];
        end
    end

    assign o_valid       = r_ov;
    assign o_origin_x    = r_o[0];
    assign o_origin_y    = r_o[1];
    assign o_origin_z    = r_o[2];
    assign o_direction_x = r_o[3];
    assign o_direction_y = r_o[4];
    assign o_direction_z = r_o[5];

endmodule

`default_nettype wire

>>> rtl/crg_norm.sv
// Pipelined integer square root and three dividers that normalize the ray direction.
`timescale 1ns / 1ps
`default_nettype none

module crg_norm (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire logic [61:0]          i_sq,
    input  wire crg_pkg::t_side       i_side,
    output logic                      o_valid,
    output logic signed [17:0]        o_u_x,
    output logic signed [17:0]        o_u_y,
    output logic signed [17:0]        o_u_z,
    output crg_pkg::t_side            o_side
);

    localparam int SQN = crg_pkg::SQ_STEPS;
    localparam int DVN = crg_pkg::DIV_STEPS;

    // Square root stage registers.
    logic [SQN-1:0]  r_sv;
    logic [61:0]     r_sx [0:SQN-1];
    logic [61:0]     r_sr [0:SQN-1];
    crg_pkg::t_side  r_ss [0:SQN-1];

    // Divider stage registers, one remainder and quotient per component.
    logic [DVN-1:0]  r_dv;
    logic [30:0]     r_dn  [0:DVN-1];
    logic [46:0]     r_rem [0:DVN-1][0:2];
    logic [16:0]     r_q   [0:DVN-1][0:2];
    crg_pkg::t_side  r_ds  [0:DVN-1];

    // Output register.
    logic                r_ov;
    logic signed [17:0]  r_u [0:2];
    crg_pkg::t_side      r_os;

    // One bit pair of the root per stage, most significant first.
    for (genvar s = 0; s < SQN; s++) begin : g_sq
        localparam logic [62:0] BIT = 63'(1) << (2 * (SQN - 1 - s));
        logic           v_in;
        logic [61:0]    x_in;
        logic [61:0]    r_in;
        crg_pkg::t_side s_in;
        logic [62:0]    trial;
        if (s == 0) begin : g_first
            assign v_in = i_valid;
            assign x_in = i_sq;
            assign r_in = '0;
            assign s_in = i_side;
        end else begin : g_next
            assign v_in = r_sv[s-1];
            assign x_in = r_sx[s-1];
            assign r_in = r_sr[s-1];
            assign s_in = r_ss[s-1];
        end
        assign trial = {1'b0, r_in} + BIT;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[s] <= 1'b0;
            end else begin
                r_sv[s] <= v_in;
            end
        end
        always_ff @(posedge i_clk) begin
            r_ss[s] <= s_in;
            if ({1'b0, x_in} >= trial) begin
                r_sx[s] <= x_in - trial[61:0];
                r_sr[s] <= (r_in >> 1) + BIT[61:0];
            end else begin
                r_sx[s] <= x_in;
                r_sr[s] <= r_in >> 1;
            end
        end
    end

    // One quotient bit per stage; the quotient never exceeds one in Q.16.
    for (genvar t = 0; t < DVN; t++) begin : g_div
        localparam int K = DVN - 1 - t;
        logic           v_in;
        logic [30:0]    n_in;
        logic [46:0]    rem_in [0:2];
        logic [16:0]    q_in   [0:2];
        crg_pkg::t_side s_in;
        logic [47:0]    dsub;
        if (t == 0) begin : g_first
            assign v_in      = r_sv[SQN-1];
            assign n_in      = r_sr[SQN-1][30:0];
            assign s_in      = r_ss[SQN-1];
            assign rem_in[0] = {r_ss[SQN-1].mag_x, 16'd0};
            assign rem_in[1] = {r_ss[SQN-1].mag_y, 16'd0};
            assign rem_in[2] = 47'(64'd1 << 32);
            assign q_in[0]   = '0;
            assign q_in[1]   = '0;
            assign q_in[2]   = '0;
        end else begin : g_next
            assign v_in = r_dv[t-1];
            assign n_in = r_dn[t-1];
            assign s_in = r_ds[t-1];
            for (genvar c = 0; c < 3; c++) begin : g_c
                assign rem_in[c] = r_rem[t-1][c];
                assign q_in[c]   = r_q[t-1][c];
            end
        end
        assign dsub = {17'd0, n_in} << K;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[t] <= 1'b0;
            end else begin
                r_dv[t] <= v_in;
            end
        end
        for (genvar c = 0; c < 3; c++) begin : g_comp
            always_ff @(posedge i_clk) begin
                if ({1'b0, rem_in[c]} >= dsub) begin
                    r_rem[t][c] <= rem_in[c] - dsub[46:0];
                    r_q[t][c]   <= {q_in[c][15:0], 1'b1};
                end else begin
                    r_rem[t][c] <= rem_in[c];
                    r_q[t][c]   <= {q_in[c][15:0], 1'b0};
                end
            end
        end
        always_ff @(posedge i_clk) begin
            r_dn[t] <= n_in;
            r_ds[t] <= s_in;
        end
    end

    // Restore the signs; the z term is always negative.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_dv[DVN-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_os   <= r_ds[DVN-1];
        r_u[0] <= r_ds[DVN-1].neg_x ? -$signed({1'b0, r_q[DVN-1][0]})
                                    :  $signed({1'b0, r_q[DVN-1][0]});
        r_u[1] <= r_ds[DVN-1].neg_y ? -$signed({1'b0, r_q[DVN-1][1]})
                                    :  $signed({1'b0, r_q[DVN-1][1]});
        r_u[2] <= -$signed({1'b0, r_q[DVN-1][2]});
    end

    assign o_valid = r_ov;
    assign o_u_x   = r_u[0];
    assign o_u_y   = r_u[1];
    assign o_u_z   = r_u[2];
    assign o_side  = r_os;

endmodule

`default_nettype wire

>>> rtl/crg_checker.sv
// Port-level checks for the camera ray generator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module crg_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_valid
);

    // The pipeline never refuses a pixel.
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy was raised");

    // Reset empties the pipeline.
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

    // Every transferred pixel gives a ray after the fixed latency.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(crg_pkg::PIPE_LATENCY) o_valid)
        else $error("ray missing at the expected cycle");

endmodule

bind camera_primary_ray_generator crg_checker u_crg_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid)
);

`default_nettype wire

>>> tb/ray_checker.sv
// Watches the pixel, config and ray channels, predicts each ray and compares it.
`timescale 1ns / 1ps

module ray_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic [15:0] i_pixel_x,
    input  wire logic [15:0] i_pixel_y,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [62:0] i_cfg_data,
    input  wire logic        i_valid,
    input  wire logic [20:0] i_origin_x,
    input  wire logic [20:0] i_origin_y,
    input  wire logic [20:0] i_origin_z,
    input  wire logic [20:0] i_direction_x,
    input  wire logic [20:0] i_direction_y,
    input  wire logic [20:0] i_direction_z,
    output int               o_errors,
    output int               o_pending
);

    // Fields in order: origin x, y, z, then direction x, y, z.
    typedef logic [5:0][20:0] t_ray;

    logic [62:0] cam_regs [8];
    t_ray        rays_due [$];
    t_ray        got_ray;
    t_ray        want_ray;
    string       field_names [6] = '{"origin_x", "origin_y", "origin_z",
                                     "direction_x", "direction_y", "direction_z"};

    assign o_pending = rays_due.size();

    function automatic longint rnd_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic [20:0] sat_out(longint v);
        longint c;
        c = v > 1048575 ? 1048575 : (v < -1048576 ? -1048576 : v);
        return c[20:0];
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Expected ray for one pixel under the current camera registers.
    function automatic t_ray trace_ray(logic [15:0] px, logic [15:0] py);
        t_ray              r;
        longint            nx, ny, sx, sy, acc, n;
        longint            pos [3];
        longint            d [3];
        longint            u [3];
        longint unsigned   sq;
        logic [62:0]       row;
        nx = 2 * (longint'(px) * longint'(cam_regs[crg_pkg::REG_RECIPS][23:0]))
             - (64'sd1 <<< 28);
        ny = 2 * (longint'(py) * longint'(cam_regs[crg_pkg::REG_RECIPS][47:24]))
             - (64'sd1 <<< 28);
        for (int i = 0; i < 3; i++)
            pos[i] = longint'(signed'(cam_regs[crg_pkg::REG_POS][21*i +: 21]));
        if (cam_regs[crg_pkg::REG_MODE][0]) begin
            r[0] = sat_out(pos[0] + rnd_shift(nx, 16));
            r[1] = sat_out(pos[1] + rnd_shift(ny, 16));
            r[2] = sat_out(pos[2]);
            for (int i = 0; i < 3; i++)
                r[3+i] = sat_out(longint'(signed'(cam_regs[crg_pkg::REG_LOOK][21*i +: 21])));
            return r;
        end
        sx = longint'(cam_regs[crg_pkg::REG_SCALES][19:0]);
        sy = longint'(cam_regs[crg_pkg::REG_SCALES][39:20]);
        d[0] = rnd_shift(rnd_shift(nx, 12) * sx, 16);
        d[1] = rnd_shift(rnd_shift(ny, 12) * sy, 16);
        // Large perspective terms saturate before normalization.
        for (int i = 0; i < 2; i++) begin
            if (d[i] > 1073741824) d[i] = 1073741824;
            if (d[i] < -1073741824) d[i] = -1073741824;
        end
        d[2] = -65536;
        sq = longint'(d[0] * d[0]) + longint'(d[1] * d[1]) + longint'(d[2] * d[2]);
        n = longint'(int_sqrt(sq));
        for (int i = 0; i < 3; i++)
            u[i] = (d[i] * 65536) / n;
        for (int i = 0; i < 3; i++) begin
            row = cam_regs[crg_pkg::REG_ROT0 + i];
            acc = 0;
            for (int j = 0; j < 3; j++)
                acc += longint'(signed'(row[19*j +: 19])) * u[j];
            r[i]   = sat_out(pos[i]);
            r[3+i] = sat_out(rnd_shift(acc, 16));
        end
        return r;
    endfunction

    // Track register writes, predict accepted pixels, compare ray transfers.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) cam_regs[i] <= '0;
            rays_due.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_we)
                cam_regs[i_cfg_idx] <= (i_cfg_idx == crg_pkg::REG_MODE)
                                       ? {62'd0, i_cfg_data[0]} : i_cfg_data;
            if (start && !busy)
                rays_due.push_back(trace_ray(i_pixel_x, i_pixel_y));
            if (i_valid) begin
                got_ray = {i_direction_z, i_direction_y, i_direction_x,
                           i_origin_z, i_origin_y, i_origin_x};
                if (rays_due.size() == 0) begin
                    if (o_errors < 10) $display("ERROR: ray with none expected");
                    o_errors <= o_errors + 1;
                end else begin
                    want_ray = rays_due.pop_front();
                    if (want_ray != got_ray) begin
                        if (o_errors < 10)
                            for (int f = 0; f < 6; f++)
                                if (want_ray[f] != got_ray[f])
                                    $display("ERROR: %s expected %0d got %0d", field_names[f],
                                             $signed(want_ray[f]), $signed(got_ray[f]));
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

>>> tb/tb_camera_primary_ray_generator.sv
// Stimulus and verdict for the camera primary ray generator.
`timescale 1ns / 1ps

module tb_camera_primary_ray_generator;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [15:0]        i_pixel_x = '0;
    logic [15:0]        i_pixel_y = '0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_idx = '0;
    logic [62:0]        i_cfg_data = '0;
    logic               o_valid;
    logic signed [20:0] o_origin_x, o_origin_y, o_origin_z;
    logic signed [20:0] o_direction_x, o_direction_y, o_direction_z;
    int                 mismatches;
    int                 rays_pending;
    bit                 no_gaps;

    localparam logic [18:0] ONE_Q16 = 19'd65536;
    localparam logic [62:0] ONES = {63{1'b1}};

    always #5 i_clk = ~i_clk;

    camera_primary_ray_generator uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_pixel_x(i_pixel_x), .i_pixel_y(i_pixel_y),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid),
        .o_origin_x(o_origin_x), .o_origin_y(o_origin_y), .o_origin_z(o_origin_z),
        .o_direction_x(o_direction_x), .o_direction_y(o_direction_y),
        .o_direction_z(o_direction_z)
    );

    ray_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_pixel_x(i_pixel_x), .i_pixel_y(i_pixel_y),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(o_valid),
        .i_origin_x(o_origin_x), .i_origin_y(o_origin_y), .i_origin_z(o_origin_z),
        .i_direction_x(o_direction_x), .i_direction_y(o_direction_y),
        .i_direction_z(o_direction_z),
        .o_errors(mismatches), .o_pending(rays_pending)
    );

    function automatic logic [62:0] rand63();
        return 63'({$urandom, $urandom});
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [62:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // Write every camera register; only called with the pipeline drained.
    task automatic load_camera(logic mode, logic [62:0] scales, logic [62:0] recips,
                               logic [62:0] r0, logic [62:0] r1, logic [62:0] r2,
                               logic [62:0] pos, logic [62:0] look);
        write_reg(crg_pkg::REG_MODE, (rand63() & ~63'd1) | 63'(mode));
        write_reg(crg_pkg::REG_SCALES, scales);
        write_reg(crg_pkg::REG_RECIPS, recips);
        write_reg(crg_pkg::REG_ROT0, r0);
        write_reg(crg_pkg::REG_ROT1, r1);
        write_reg(crg_pkg::REG_ROT2, r2);
        write_reg(crg_pkg::REG_POS, pos);
        write_reg(crg_pkg::REG_LOOK, look);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // One pixel transfer, with an optional random gap in front of it.
    task automatic send_pixel(logic [15:0] px, logic [15:0] py);
        bit waiting;
        while (!no_gaps && $urandom_range(99) < 21) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start     <= 1'b1;
        i_pixel_x <= px;
        i_pixel_y <= py;
        do begin
            waiting = busy;
            @(posedge i_clk);
            if (waiting) @(negedge i_clk);
        end while (waiting);
    endtask

    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        wait (rays_pending == 0);
    endtask

    task automatic load_typical(logic mode);
        load_camera(mode, {23'd0, 20'd32768, 20'd43690}, {15'd0, 24'd34953, 24'd26214},
                    {6'd0, 19'd0, 19'd0, ONE_Q16}, {6'd0, 19'd0, ONE_Q16, 19'd0},
                    {6'd0, ONE_Q16, 19'd0, 19'd0},
                    {21'd4096, 21'h1FF000, 21'd8192}, {21'h1FF000, 21'd0, 21'd0});
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset registers, typical camera, all-ones, extreme positions and orthographic mode.
        no_gaps = 1'b1;
        send_pixel(16'h0000, 16'h0000);
        send_pixel(16'hFFFF, 16'hFFFF);
        drain();
        load_typical(1'b0);
        send_pixel(16'd0, 16'd0);
        send_pixel(16'd5120, 16'd3840);
        send_pixel(16'd10240, 16'd7680);
        send_pixel(16'd10239, 16'd1);
        send_pixel(16'hFFFF, 16'h0000);
        send_pixel(16'h0000, 16'hFFFF);
        drain();
        load_camera(1'b0, ONES, ONES, ONES, ONES, ONES, ONES, ONES);
        send_pixel(16'hFFFF, 16'hFFFF);
        send_pixel(16'h0000, 16'h0000);
        send_pixel(16'h8000, 16'h7FFF);
        drain();
        load_camera(1'b0, ONES, ONES, {6'd0, {3{19'h20000}}}, {6'd0, {3{19'h1FFFF}}},
                    rand63(), {21'h0FFFFF, 21'h100000, 21'h0FFFFF}, '0);
        send_pixel(16'hFFFF, 16'h0000);
        send_pixel(16'h0000, 16'hFFFF);
        drain();
        load_camera(1'b1, rand63(), ONES, rand63(), rand63(), rand63(),
                    {21'h100000, 21'h0FFFFF, 21'h100000}, {21'h100000, 21'h0FFFFF, 21'h100000});
        send_pixel(16'hFFFF, 16'h0000);
        send_pixel(16'h0000, 16'hFFFF);
        send_pixel(16'hFFFF, 16'hFFFF);
        drain();
        load_camera(1'b1, '0, '0, '0, '0, '0, '0, ONES);
        send_pixel(16'h1234, 16'hFEDC);
        drain();

        // Random phases: each loads either a typical camera or random register contents.
        for (int ph = 0; ph < 8; ph++) begin
            no_gaps = (ph == 2);
            if ($urandom_range(1))
                load_typical($urandom_range(1));
            else
                load_camera($urandom_range(1), rand63(), rand63(), rand63(), rand63(),
                            rand63(), rand63(), rand63());
            for (int k = 0; k < 50; k++) begin
                if (ph == 4 && k == 25) drain();
                if ($urandom_range(99) < 70)
                    send_pixel(16'($urandom_range(10240)), 16'($urandom_range(7680)));
                else
                    send_pixel(16'($urandom), 16'($urandom));
            end
            drain();
        end

        repeat (crg_pkg::PIPE_LATENCY + 10) @(posedge i_clk);
        if (mismatches == 0 && rays_pending == 0) begin
            $display("** camera_primary_ray_generator: PASSED **");
        end else begin
            $display("** camera_primary_ray_generator: FAILED **");
        end
        $finish;
    end

    // Hard stop in case the block never delivers.
    initial begin
        #2000000;
        $display("** camera_primary_ray_generator: FAILED **");
        $finish;
    end

endmodule

>>> sim.f
rtl/crg_pkg.sv
rtl/crg_norm.sv
rtl/camera_primary_ray_generator.sv
rtl/crg_checker.sv
tb/ray_checker.sv
tb/tb_camera_primary_ray_generator.sv
